// ===== rtl/hte_pkg.sv =====
package hte_pkg;

   // Fixed field widths of the command stream.
   localparam int CMD_W   = 2;
   localparam int SYM_W   = 8;
   localparam int CODE_W  = 32;
   localparam int LEN_W   = 6;
   localparam int BYTE_W  = 8;

   // Packing window: up to seven pending bits plus one full code word.
   localparam int WIN_W   = BYTE_W + CODE_W;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd3;

   // One unit of work for the bit packer.
   typedef struct packed {
      logic              flush;
      logic [CODE_W-1:0] bits;
      logic [LEN_W-1:0]  len;
   } hte_entry_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic not_full;
      logic head_valid;
   } hte_qstat_type;

endpackage

// ===== rtl/huffman_table_encoder_packer_core.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_tvalid/tready    tuser: command; tdata: symbol, code, length
// rsp       out        rsp_tvalid/tready    tdata: packed byte; tlast: final byte of item
//
// A new item is taken every cycle while the queue has room; an item that completes
// k bytes holds the packer until its k-th byte leaves, one per cycle unless stalled.
// An item passes the table read, the queue and the output register on its way to
// the first byte. A four-entry queue lets input run while bytes drain. Reset clears
// the packer and the queue, not the table; the user must load an entry before it is
// read, which the block does not enforce. Either side may stall without losing items.
module huffman_table_encoder_packer_core
   import hte_pkg::*;
#(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // symbol[7:0], code_bits[39:8], code_length[45:40], zero
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte[7:0]
   output logic        rsp_tlast
);

   hte_qstat_type q_stat;
   hte_entry_type push_entry;
   hte_entry_type head;
   logic          q_push;
   logic          q_pop;

   // Front: table access and word selection.
   hte_front #(
      .MAX_CODE_LEN(MAX_CODE_LEN),
      .SYMBOL_COUNT(SYMBOL_COUNT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_command     (req_tuser),
      .in_symbol      (req_tdata[7:0]),
      .in_code_bits   (req_tdata[39:8]),
      .in_code_length (req_tdata[45:40]),
      .q_stat         (q_stat),
      .q_push         (q_push),
      .q_entry        (push_entry)
   );

   // Queue between front and back.
   hte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .stat       (q_stat)
   );

   // Back: bit packer and output register.
   hte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_stat    (q_stat),
      .pop       (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

// ===== rtl/hte_ram.sv =====
module hte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single port with a registered read that holds while not enabled.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hte_front.sv =====
module hte_front
   import hte_pkg::*;
#(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [CMD_W-1:0]  in_command,
   input  logic [SYM_W-1:0]  in_symbol,
   input  logic [CODE_W-1:0] in_code_bits,
   input  logic [LEN_W-1:0]  in_code_length,
   input  hte_qstat_type     q_stat,
   output logic              q_push,
   output hte_entry_type     q_entry
);

   localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
   localparam int LEN_LIM = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

   logic                     accept;
   logic                     in_range;
   logic                     ram_wr;
   logic                     ram_rd;
   logic [CODE_W+LEN_W-1:0]  ram_q;

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_enc_ff;
   logic                     s1_flush_ff;
   logic [CODE_W-1:0]        s1_bits_ff;
   logic [LEN_W-1:0]         s1_len_ff;

   logic [CODE_W-1:0]        raw_bits;
   logic [LEN_W-1:0]         raw_len;
   logic [LEN_W-1:0]         use_len;

   // Accept while stage one is empty or moving into the queue.
   assign in_ready = !s1_valid_ff || q_stat.not_full;
   assign accept   = in_valid && in_ready;
   assign in_range = {1'b0, in_symbol} < (SYM_W + 1)'(SYMBOL_COUNT);

   // Loads write the table, encodes read it; both use the one port.
   assign ram_wr = accept && (in_command == CMD_LOAD) && in_range;
   assign ram_rd = accept && (in_command == CMD_ENCODE);

   hte_ram #(
      .WIDTH(CODE_W + LEN_W),
      .DEPTH(SYMBOL_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr),
      .rd_en   (ram_rd),
      .addr    (in_symbol[ADDR_W-1:0]),
      .wr_data ({in_code_length, in_code_bits}),
      .rd_data (ram_q)
   );

   // Stage one holds every item that reaches the packer.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = ((in_command == CMD_ENCODE) && in_range) ||
                       (in_command == CMD_APPEND) || (in_command == CMD_FLUSH);
      end else if (q_stat.not_full) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_enc_ff   <= (in_command == CMD_ENCODE);
         s1_flush_ff <= (in_command == CMD_FLUSH);
         s1_bits_ff  <= in_code_bits;
         s1_len_ff   <= in_code_length;
      end
   end

   // Pick the table or literal word, saturate its length, drop unused bits.
   assign raw_bits = s1_enc_ff ? ram_q[CODE_W-1:0] : s1_bits_ff;
   assign raw_len  = s1_enc_ff ? ram_q[CODE_W+LEN_W-1:CODE_W] : s1_len_ff;
   assign use_len  = (raw_len > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : raw_len;

   assign q_push        = s1_valid_ff && q_stat.not_full;
   assign q_entry.flush = s1_flush_ff;
   assign q_entry.len   = s1_flush_ff ? '0 : use_len;
   assign q_entry.bits  = raw_bits & ~({CODE_W{1'b1}} << use_len);

`ifndef NO_ASSERTIONS
   // A held item stays in stage one until the queue takes it.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !q_stat.not_full |=> s1_valid_ff)
      else $error("stage one item lost while the queue was full");
`endif

endmodule

// ===== rtl/hte_queue.sv =====
module hte_queue
   import hte_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  hte_entry_type push_entry,
   input  logic          pop,
   output hte_entry_type head,
   output hte_qstat_type stat
);

   hte_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;

   assign stat.not_full   = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign stat.head_valid = (count_ff != '0);
   assign head            = slot_ff[rd_ptr_ff];

   // Storage for queued items.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

`ifndef NO_ASSERTIONS
   // Neither side may overrun the queue.
   a_q_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && !stat.not_full))
      else $error("push into a full queue");
   a_q_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> stat.head_valid)
      else $error("pop from an empty queue");
`endif

endmodule

// ===== rtl/hte_back.sv =====
module hte_back
   import hte_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  hte_entry_type     head,
   input  hte_qstat_type     q_stat,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [BYTE_W-1:0] out_byte,
   output logic              out_last
);

   localparam int CNT_W = $clog2(WIN_W + 1);

   logic                     busy_ff;
   logic [WIN_W-1:0]         wbuf_ff;
   logic [CNT_W-1:0]         wcnt_ff;
   logic [BYTE_W-1:0]        pend_ff;
   logic [2:0]               pcnt_ff;
   logic                     out_valid_ff;
   logic [BYTE_W-1:0]        out_byte_ff;
   logic                     out_last_ff;

   logic [CNT_W-1:0]         total;
   logic [WIN_W-1:0]         comb_buf;
   logic [WIN_W-1:0]         src_buf;
   logic [CNT_W-1:0]         src_cnt;
   logic [WIN_W-1:0]         rem_buf;
   logic [CNT_W-1:0]         rem_cnt;
   logic                     src_have;
   logic                     out_free;
   logic                     emit;
   logic                     quiet;

   // Merge the pending bits with the new word, left-aligned in the window.
   assign total    = CNT_W'(pcnt_ff) + CNT_W'(head.len);
   assign comb_buf = {pend_ff, {CODE_W{1'b0}}} |
                     ({{BYTE_W{1'b0}}, head.bits} << (CNT_W'(WIN_W) - total));

   // Source: leftover bytes of the current item, else the queue head.
   always_comb begin
      if (busy_ff) begin
         src_buf = wbuf_ff;
         src_cnt = wcnt_ff;
      end else if (head.flush) begin
         src_buf = {pend_ff, {CODE_W{1'b0}}};
         src_cnt = (pcnt_ff != 3'd0) ? CNT_W'(BYTE_W) : '0;
      end else begin
         src_buf = comb_buf;
         src_cnt = total;
      end
   end

   assign src_have = busy_ff || q_stat.head_valid;
   assign out_free = !out_valid_ff || out_ready;
   assign rem_buf  = src_buf << BYTE_W;
   assign rem_cnt  = src_cnt - CNT_W'(BYTE_W);
   assign emit     = src_have && (src_cnt >= CNT_W'(BYTE_W)) && out_free;
   assign quiet    = !busy_ff && q_stat.head_valid && (src_cnt < CNT_W'(BYTE_W));
   assign pop      = !busy_ff && q_stat.head_valid && (emit || quiet);

   // Packer state: one byte leaves per cycle while the output is free, the rest stays pending.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= '0;
         pcnt_ff <= '0;
      end else if (emit) begin
         if (rem_cnt >= CNT_W'(BYTE_W)) begin
            busy_ff <= 1'b1;
         end else begin
            busy_ff <= 1'b0;
            pend_ff <= rem_buf[WIN_W-1 -: BYTE_W];
            pcnt_ff <= rem_cnt[2:0];
         end
      end else if (quiet) begin
         pend_ff <= src_buf[WIN_W-1 -: BYTE_W];
         pcnt_ff <= src_cnt[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         wbuf_ff <= rem_buf;
         wcnt_ff <= rem_cnt;
      end
   end

   // Output register parts the packer from the result channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff <= src_buf[WIN_W-1 -: BYTE_W];
         out_last_ff <= (rem_cnt < CNT_W'(BYTE_W));
      end
   end

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_last  = out_last_ff;

`ifndef NO_ASSERTIONS
   // While an item still owns the window it holds at least one whole byte.
   a_busy_full_byte: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (wcnt_ff >= CNT_W'(BYTE_W)) && (wcnt_ff < CNT_W'(CODE_W)))
      else $error("busy window without a whole byte");
   // A byte that ends an item frees the packer for the next one.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      emit && (rem_cnt < CNT_W'(BYTE_W)) |=> !busy_ff)
      else $error("packer stayed busy after the last byte of an item");
`endif

endmodule
